/* rtl/consensus_replication_tracker_assert.svh */
// Assertion macros shared by the tracker RTL.
`ifndef CONSENSUS_REPLICATION_TRACKER_ASSERT_SVH
`define CONSENSUS_REPLICATION_TRACKER_ASSERT_SVH

// Property checked at every edge outside reset.
`define CRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/crt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_pkg
// Shared constants and types of the replication tracker.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int MAX_PEERS = 8;
  localparam int LOG_DEPTH = 1024;
  localparam int LOG_AW    = $clog2(LOG_DEPTH);
  localparam int PEER_W    = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int IDX_W     = 10;
  localparam int TERM_W    = 32;
  localparam int VOTE_W    = $clog2(MAX_PEERS + 2);

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_REPLY  = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic REG_CLUSTER_SIZE = 1'b0;
  localparam logic REG_CURRENT_TERM = 1'b1;

  typedef struct packed {
    logic              done;
    logic              advanced;
    logic [IDX_W-1:0]  commit;
  } walk_res_t;

  typedef struct packed {
    logic [IDX_W-1:0]  commit_index;
    logic              commit_advanced;
    logic [IDX_W-1:0]  prev_index;
    logic [TERM_W-1:0] prev_term;
    logic [IDX_W:0]    send_first_index;
    logic [IDX_W-1:0]  send_last_index;
    logic              step_down;
    logic              log_full;
  } result_t;

endpackage

/* rtl/crt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/crt_commit_walk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_commit_walk
// Walks the commit index forward one log entry at a time, alternating W_READ and W_EVAL.
// ----------------------------------------------------------------------------
module crt_commit_walk (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [crt_pkg::IDX_W-1:0]     commit_i,
  input  logic [crt_pkg::IDX_W-1:0]     last_i,
  input  logic [crt_pkg::TERM_W-1:0]    term_i,
  input  logic [3:0]                    cluster_i,
  input  logic [crt_pkg::IDX_W-1:0]     match_i [crt_pkg::MAX_PEERS],
  output logic [crt_pkg::LOG_AW-1:0]    rd_addr_o,
  input  logic [crt_pkg::TERM_W-1:0]    rd_data_i,
  output logic                          busy_o,
  output crt_pkg::walk_res_t            res_o
);
  import crt_pkg::*;

  localparam logic [1:0] W_IDLE = 2'd0;
  localparam logic [1:0] W_READ = 2'd1;
  localparam logic [1:0] W_EVAL = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IDX_W:0]   n_q, n_d;
  logic [IDX_W-1:0] best_q, best_d, base_q, base_d;
  logic [4:0]       members;
  logic [VOTE_W-1:0] votes;
  logic             finish;

  // members = min(cluster_size - 1, MAX_PEERS), 0 when cluster_size is 0
  always_comb begin
    members = (cluster_i == 4'd0) ? 5'd0 : 5'({1'b0, cluster_i} - 5'd1);
    if (32'(members) > MAX_PEERS) members = 5'(MAX_PEERS);
  end

  always_comb begin
    votes = VOTE_W'(1);
    for (int p = 0; p < MAX_PEERS; p++) begin
      if (p < 32'(members) && {1'b0, match_i[p]} >= n_q) votes = votes + VOTE_W'(1);
    end
  end

  assign rd_addr_o = LOG_AW'(n_q);
  assign busy_o    = (state_q != W_IDLE);

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    best_d  = best_q;
    base_d  = base_q;
    finish  = 1'b0;
    case (state_q)
      W_IDLE: begin
        if (start_i) begin
          n_d     = {1'b0, commit_i} + (IDX_W+1)'(1);
          best_d  = commit_i;
          base_d  = commit_i;
          state_d = W_READ;
        end
      end
      W_READ: begin
        if (n_q > {1'b0, last_i}) begin
          finish  = 1'b1;
          state_d = W_IDLE;
        end else begin
          state_d = W_EVAL;
        end
      end
      W_EVAL: begin
        if (rd_data_i > term_i) begin
          finish  = 1'b1;
          state_d = W_IDLE;
        end else begin
          if (rd_data_i == term_i && 32'(votes) > 32'(cluster_i >> 1)) begin
            best_d = IDX_W'(n_q);
          end
          n_d     = n_q + (IDX_W+1)'(1);
          state_d = W_READ;
        end
      end
      default: state_d = W_IDLE;
    endcase
  end

  assign res_o.done     = finish;
  assign res_o.advanced = finish && (best_q != base_q);
  assign res_o.commit   = best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    best_q <= best_d;
    base_q <= base_d;
  end

endmodule

/* rtl/consensus_replication_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// consensus_replication_tracker
// Leader-side log replication bookkeeping and commit index tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command item: append,
//   peer reply or heartbeat query. Output channel (out_valid_o/out_ready_i)
//   returns exactly one result item per command.
//   Config port: cfg_we_i writes cluster_size (index 0) or current_term
//   (index 1); write only while the block is idle.
// Flow: each item passes states before S_DONE loads the output register:
//   append, unused command, reply without success: straight to S_DONE.
//   query: S_QRD first (one log RAM read).
//   reply with success: S_WSTRT, then S_WALK until the walk passes the
//   last index or meets an entry of a later term;
//   the commit walk reads one log entry at a time through the single
//   RAM read port and counts the votes of all peers combinationally.
// Throughput: one item at a time; in_ready_o is low while an item is in work
//   and rises in the same cycle as its result is loaded.
// Reset: last index, commit index, match indices clear to 0, next indices
//   to 1. The log RAM is not cleared; entry 0 is never written, a query returns term 0 for it.
// Stall: the result waits in the output register; a new item is still taken,
//   and the block holds its next result until the register drains.
// ----------------------------------------------------------------------------
module consensus_replication_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [2:0]  peer_i,
  input  logic [31:0] entry_term_i,
  input  logic        reply_success_i,
  input  logic        reply_inconsistent_i,
  input  logic [9:0]  reply_last_index_i,
  input  logic [31:0] reply_term_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  commit_index_o,
  output logic        commit_advanced_o,
  output logic [9:0]  prev_index_o,
  output logic [31:0] prev_term_o,
  output logic [10:0] send_first_index_o,
  output logic [9:0]  send_last_index_o,
  output logic        step_down_o,
  output logic        log_full_o
);
  import crt_pkg::*;

  `include "consensus_replication_tracker_assert.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_QRD   = 3'd1;
  localparam logic [2:0] S_WSTRT = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [3:0]        cluster_q;
  logic [TERM_W-1:0] term_q;
  logic [IDX_W-1:0]  last_q, last_d;
  logic [IDX_W-1:0]  commit_q, commit_d;
  logic [IDX_W:0]    next_q [MAX_PEERS];
  logic [IDX_W:0]    next_d [MAX_PEERS];
  logic [IDX_W-1:0]  match_q [MAX_PEERS];
  logic [IDX_W-1:0]  match_d [MAX_PEERS];
  result_t           res_q, res_d, out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              accept, peer_ok, walk_start, walk_busy;
  logic [PEER_W-1:0] pidx;
  logic [IDX_W:0]    nx;
  logic              ram_we;
  logic [LOG_AW-1:0] ram_waddr, ram_raddr, walk_addr;
  logic [TERM_W-1:0] ram_rdata;
  walk_res_t         walk_res;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign peer_ok    = 32'(peer_i) < MAX_PEERS;
  assign pidx       = PEER_W'(peer_i);
  assign nx         = peer_ok ? next_q[pidx] : (IDX_W+1)'(1);
  assign walk_start = (state_q == S_WSTRT);

  assign ram_we    = accept && command_i == CMD_APPEND && 32'(last_q) + 1 < LOG_DEPTH;
  assign ram_waddr = LOG_AW'(last_q + IDX_W'(1));
  assign ram_raddr = (state_q == S_IDLE) ? LOG_AW'(nx - (IDX_W+1)'(1)) : walk_addr;

  crt_ram #(.WIDTH(TERM_W), .DEPTH(LOG_DEPTH)) u_log (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (entry_term_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  crt_commit_walk u_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (walk_start),
    .commit_i  (commit_q),
    .last_i    (last_q),
    .term_i    (term_q),
    .cluster_i (cluster_q),
    .match_i   (match_q),
    .rd_addr_o (walk_addr),
    .rd_data_i (ram_rdata),
    .busy_o    (walk_busy),
    .res_o     (walk_res)
  );

  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    commit_d    = commit_q;
    next_d      = next_q;
    match_d     = match_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d   = '0;
          state_d = S_DONE;
          case (command_i)
            CMD_APPEND: begin
              if (ram_we) last_d = last_q + IDX_W'(1);
              else res_d.log_full = 1'b1;
            end
            CMD_REPLY: begin
              res_d.step_down = reply_term_i > term_q;
              if (peer_ok) begin
                if (reply_success_i) begin
                  match_d[pidx] = reply_last_index_i;
                  next_d[pidx]  = {1'b0, reply_last_index_i} + (IDX_W+1)'(1);
                  state_d       = S_WSTRT;
                end else if (reply_inconsistent_i && next_q[pidx] > (IDX_W+1)'(1)) begin
                  next_d[pidx] = next_q[pidx] - (IDX_W+1)'(1);
                end
              end
            end
            CMD_QUERY: begin
              res_d.prev_index       = IDX_W'(nx - (IDX_W+1)'(1));
              res_d.send_first_index = nx;
              res_d.send_last_index  = last_q;
              state_d                = S_QRD;
            end
            default: ;
          endcase
        end
      end
      S_QRD: begin
        // entry 0 is never written; for it and entries past the log prev_term stays 0
        if (res_q.prev_index != '0 && res_q.prev_index <= last_q) begin
          res_d.prev_term = ram_rdata;
        end
        state_d = S_DONE;
      end
      S_WSTRT: state_d = S_WALK;
      S_WALK: begin
        if (walk_res.done) begin
          commit_d              = walk_res.commit;
          res_d.commit_advanced = walk_res.advanced;
          state_d               = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d              = res_q;
          out_d.commit_index = commit_q;
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cluster_q   <= 4'd1;
      term_q      <= '0;
      last_q      <= '0;
      commit_q    <= '0;
      out_valid_q <= 1'b0;
      for (int p = 0; p < MAX_PEERS; p++) begin
        next_q[p]  <= (IDX_W+1)'(1);
        match_q[p] <= '0;
      end
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      commit_q    <= commit_d;
      out_valid_q <= out_valid_d;
      next_q      <= next_d;
      match_q     <= match_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_CLUSTER_SIZE: cluster_q <= cfg_data_i[3:0];
          REG_CURRENT_TERM: term_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o        = out_valid_q;
  assign commit_index_o     = out_q.commit_index;
  assign commit_advanced_o  = out_q.commit_advanced;
  assign prev_index_o       = out_q.prev_index;
  assign prev_term_o        = out_q.prev_term;
  assign send_first_index_o = out_q.send_first_index;
  assign send_last_index_o  = out_q.send_last_index;
  assign step_down_o        = out_q.step_down;
  assign log_full_o         = out_q.log_full;

  `CRT_ASSERT(a_commit_le_last, commit_q <= last_q, "commit index past last index")
  `CRT_ASSERT_NEXT(a_commit_mono, 1'b1, commit_q >= $past(commit_q), "commit index moved back")
  `CRT_ASSERT(a_walk_blocks_input, !(walk_busy && in_ready_o), "input taken during walk")

endmodule
